// ===== rtl/word_stack_with_dup_swap_assert.svh =====
// assertion macros for the word stack block
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef WORD_STACK_WITH_DUP_SWAP_ASSERT_SVH
`define WORD_STACK_WITH_DUP_SWAP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define WSDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define WSDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsds_pkg.sv =====
// shared types and constants for the word stack block
// no dependencies
package wsds_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int MAX_REACH   = 16;

    localparam int LIMB_W      = 64;
    localparam int WORD_W      = 4 * LIMB_W;
    localparam int POS_W       = 10;
    localparam int TYPE_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_NOW_W = 11;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    // subtractor width: enough for depth and for position plus one, plus a borrow bit
    localparam int SUB_W  = ((CNT_W > POS_W + 1) ? CNT_W : POS_W + 1) + 1;

    typedef enum logic [TYPE_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_GET   = 3'd2,
        OP_SET   = 3'd3,
        OP_DUP   = 3'd4,
        OP_SWAP  = 3'd5,
        OP_CLEAR = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_OVER  = 3'd1,
        ST_UNDER = 3'd2,
        ST_RANGE = 3'd3,
        ST_COUNT = 3'd4
    } t_status;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [POS_W-1:0]  position;
        logic [LIMB_W-1:0] data_w0;
        logic [LIMB_W-1:0] data_w1;
        logic [LIMB_W-1:0] data_w2;
        logic [LIMB_W-1:0] data_w3;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [LIMB_W-1:0]      read_w0;
        logic [LIMB_W-1:0]      read_w1;
        logic [LIMB_W-1:0]      read_w2;
        logic [LIMB_W-1:0]      read_w3;
        logic [DEPTH_NOW_W-1:0] depth_now;
    } t_res;

    typedef struct packed {
        logic [LIMB_W-1:0] w3;
        logic [LIMB_W-1:0] w2;
        logic [LIMB_W-1:0] w1;
        logic [LIMB_W-1:0] w0;
    } t_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_cmd;

endpackage

// ===== rtl/wsds_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module wsds_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wsds_seq.sv =====
// sequencer of the word stack: checks, shared address subtractor, ram steps
// depends on wsds_pkg
module wsds_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  wsds_pkg::t_req        i_req,
    input  logic [wsds_pkg::WORD_W-1:0] i_rdata,
    output wsds_pkg::t_ram_cmd    o_ram,
    output logic                  o_busy,
    output logic                  o_done,
    output wsds_pkg::t_res        o_res
);
    import wsds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD_WAIT,
        S_SWAP_TOP,
        S_SWAP_WR1,
        S_SWAP_WR2
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_depth, n_depth;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [WORD_W-1:0] r_tmp, n_tmp;
    logic              r_done, n_done;
    t_res              r_res, n_res;

    logic [SUB_W-1:0]  sub_off;
    logic [SUB_W-1:0]  sub_out;
    logic              borrow;
    logic [ADDR_W-1:0] sub_addr;
    logic [CNT_W-1:0]  depth_inc;
    logic              count_bad;
    logic              full;
    t_word             rd_word;
    t_word             in_word;
    t_op               op;
    t_status           status;
    logic              rd_use;

    assign op        = t_op'(i_req.req_type);
    assign rd_word   = t_word'(i_rdata);
    assign in_word   = '{w3: i_req.data_w3, w2: i_req.data_w2,
                         w1: i_req.data_w1, w0: i_req.data_w0};
    assign count_bad = (i_req.position == '0) ||
                       (i_req.position > POS_W'(MAX_REACH));
    assign full      = (r_depth >= CNT_W'(STACK_DEPTH));
    assign depth_inc = r_depth + CNT_W'(1);

    // shared subtractor: depth minus an offset, top bit is the borrow
    always_comb begin
        sub_off = SUB_W'(1);
        if (r_state == S_CHECK) begin
            unique case (op) inside
                OP_GET, OP_SET, OP_SWAP: sub_off = SUB_W'(i_req.position) + SUB_W'(1);
                OP_DUP:                  sub_off = SUB_W'(i_req.position);
                default:                 sub_off = SUB_W'(1);
            endcase
        end
    end

    assign sub_out  = SUB_W'(r_depth) - sub_off;
    assign borrow   = sub_out[SUB_W-1];
    assign sub_addr = sub_out[ADDR_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_addr     = r_addr;
        n_tmp      = r_tmp;
        n_done     = 1'b0;
        status     = ST_OK;
        rd_use     = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_depth[ADDR_W-1:0];
        o_ram.wdata = in_word;
        o_ram.raddr = sub_addr;

        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (op)
                    OP_PUSH: begin
                        if (full) begin
                            status = ST_OVER;
                        end else begin
                            o_ram.we = 1'b1;
                            n_depth  = depth_inc;
                        end
                    end
                    OP_POP: begin
                        if (borrow) begin
                            status = ST_UNDER;
                        end else begin
                            n_depth = sub_out[CNT_W-1:0];
                            n_state = S_RD_WAIT;
                            n_done  = 1'b0;
                        end
                    end
                    OP_GET: begin
                        if (borrow) begin
                            status = ST_RANGE;
                        end else begin
                            n_state = S_RD_WAIT;
                            n_done  = 1'b0;
                        end
                    end
                    OP_SET: begin
                        if (borrow) begin
                            status = ST_RANGE;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = sub_addr;
                        end
                    end
                    OP_DUP: begin
                        if (count_bad) begin
                            status = ST_COUNT;
                        end else if (borrow) begin
                            status = ST_UNDER;
                        end else if (full) begin
                            status = ST_OVER;
                        end else begin
                            n_state = S_RD_WAIT;
                            n_done  = 1'b0;
                        end
                    end
                    OP_SWAP: begin
                        if (count_bad) begin
                            status = ST_COUNT;
                        end else if (borrow) begin
                            status = ST_UNDER;
                        end else begin
                            // lower slot read now, top slot read next
                            n_addr  = sub_addr;
                            n_state = S_SWAP_TOP;
                            n_done  = 1'b0;
                        end
                    end
                    OP_CLEAR: begin
                        n_depth = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_WAIT: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                rd_use  = 1'b1;
                if (op == OP_DUP) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = i_rdata;
                    n_depth     = depth_inc;
                end
            end
            S_SWAP_TOP: begin
                n_tmp   = i_rdata;
                n_state = S_SWAP_WR1;
            end
            S_SWAP_WR1: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr;
                o_ram.wdata = i_rdata;
                n_state     = S_SWAP_WR2;
            end
            S_SWAP_WR2: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = sub_addr;
                o_ram.wdata = r_tmp;
                n_state     = S_IDLE;
                n_done      = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.status    = status;
        n_res.read_w0   = rd_use ? rd_word.w0 : '0;
        n_res.read_w1   = rd_use ? rd_word.w1 : '0;
        n_res.read_w2   = rd_use ? rd_word.w2 : '0;
        n_res.read_w3   = rd_use ? rd_word.w3 : '0;
        n_res.depth_now = DEPTH_NOW_W'(n_depth);
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_tmp  <= n_tmp;
        r_res  <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/word_stack_with_dup_swap.sv =====
// top level of the 256-bit word stack with dup and swap
// depends on wsds_pkg, wsds_seq, wsds_ram and the assertion macro header
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------
//  request   | start / busy       | i_req  (t_req: type, position, word)
//  result    | o_done strobe      | o_res  (t_res: status, word, depth)
//
// a request is taken at an edge with start high and busy low
// push, set, clear, unused codes and failed requests end in the check state
// pop, get and dup add a wait state for one registered ram read
// swap reads twice, then writes twice, through the single ram port pair
// synchronous active-low reset empties the stack; the ram itself is never cleared
// the result strobe lasts one cycle and cannot be stalled
`include "word_stack_with_dup_swap_assert.svh"

module word_stack_with_dup_swap (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  wsds_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output wsds_pkg::t_res o_res
);
    import wsds_pkg::*;

    // request is held here for the whole sequence
    t_req              r_req;
    logic              accept;
    logic              seq_busy;
    t_ram_cmd          ram_cmd;
    logic [WORD_W-1:0] ram_rdata;

    assign accept = start && !seq_busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    // sequencer: checks, address subtractor, depth counter, result register
    wsds_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_req   (r_req),
        .i_rdata (ram_rdata),
        .o_ram   (ram_cmd),
        .o_busy  (seq_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // stack storage: one 256-bit word per slot, all four limbs together
    wsds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (ram_cmd.wdata),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (ram_rdata)
    );

    assign busy = seq_busy;

    // a taken request keeps the block busy in the following cycle
    `WSDS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accept")

    // the result appears only once the sequence has ended
    `WSDS_ASSERT_NOW(a_done_not_busy, o_done, !busy, "result while busy")

    // depth never goes past the capacity
    `WSDS_ASSERT_NOW(a_depth_bound, o_done,
        o_res.depth_now <= DEPTH_NOW_W'(STACK_DEPTH), "depth beyond capacity")

    // a failed request returns an all-zero word
    `WSDS_ASSERT_NOW(a_fail_zero, o_done && (o_res.status != ST_OK),
        (o_res.read_w0 == '0) && (o_res.read_w1 == '0) &&
        (o_res.read_w2 == '0) && (o_res.read_w3 == '0), "nonzero word on failure")

endmodule

// ===== dv/wsds_stack_checker.sv =====
`timescale 1ns / 100ps
// result checker for the word stack: mirrors the stack on every accepted request
// and compares each result strobe against the oldest predicted result
// depends on wsds_pkg only
module wsds_stack_checker
    import wsds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_busy,
    input  t_req  i_req,
    input  logic  i_done,
    input  t_res  i_res,
    output int    o_fail_count,
    output int    o_pending
);

    t_word       word_mem [STACK_DEPTH];
    int unsigned stk_depth = 0;
    t_res        due_results [$];
    int          mismatch_count = 0;
    int          queued_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = queued_count;

    // apply one request to the mirrored stack, return the result it must produce
    function automatic t_res apply_request(input t_req r);
        t_res        res;
        t_word       w;
        t_word       rd;
        t_word       tmp;
        int unsigned pos;
        int unsigned top_slot;
        int unsigned far_slot;
        res  = '0;
        rd   = '0;
        pos  = r.position;
        w.w0 = r.data_w0;
        w.w1 = r.data_w1;
        w.w2 = r.data_w2;
        w.w3 = r.data_w3;
        case (r.req_type)
            OP_PUSH: begin
                if (stk_depth >= STACK_DEPTH) begin
                    res.status = ST_OVER;
                end else begin
                    word_mem[stk_depth] = w;
                    stk_depth++;
                end
            end
            OP_POP: begin
                if (stk_depth == 0) begin
                    res.status = ST_UNDER;
                end else begin
                    stk_depth--;
                    rd = word_mem[stk_depth];
                end
            end
            OP_GET: begin
                if (pos >= stk_depth) begin
                    res.status = ST_RANGE;
                end else begin
                    rd = word_mem[stk_depth - 1 - pos];
                end
            end
            OP_SET: begin
                if (pos >= stk_depth) begin
                    res.status = ST_RANGE;
                end else begin
                    word_mem[stk_depth - 1 - pos] = w;
                end
            end
            OP_DUP: begin
                // count check first, then underflow, then overflow
                if (pos < 1 || pos > MAX_REACH) begin
                    res.status = ST_COUNT;
                end else if (stk_depth < pos) begin
                    res.status = ST_UNDER;
                end else if (stk_depth >= STACK_DEPTH) begin
                    res.status = ST_OVER;
                end else begin
                    rd = word_mem[stk_depth - pos];
                    word_mem[stk_depth] = rd;
                    stk_depth++;
                end
            end
            OP_SWAP: begin
                if (pos < 1 || pos > MAX_REACH) begin
                    res.status = ST_COUNT;
                end else if (stk_depth < pos + 1) begin
                    res.status = ST_UNDER;
                end else begin
                    top_slot = stk_depth - 1;
                    far_slot = top_slot - pos;
                    tmp = word_mem[top_slot];
                    word_mem[top_slot] = word_mem[far_slot];
                    word_mem[far_slot] = tmp;
                end
            end
            OP_CLEAR: begin
                stk_depth = 0;
            end
            default: begin
            end
        endcase
        res.read_w0   = rd.w0;
        res.read_w1   = rd.w1;
        res.read_w2   = rd.w2;
        res.read_w3   = rd.w3;
        res.depth_now = DEPTH_NOW_W'(stk_depth);
        return res;
    endfunction

    task automatic compare_result(input t_res exp_res, input t_res got);
        if (got.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, got.status);
            mismatch_count++;
        end
        if (got.read_w0 !== exp_res.read_w0) begin
            $error("read_w0: expected %h, got %h", exp_res.read_w0, got.read_w0);
            mismatch_count++;
        end
        if (got.read_w1 !== exp_res.read_w1) begin
            $error("read_w1: expected %h, got %h", exp_res.read_w1, got.read_w1);
            mismatch_count++;
        end
        if (got.read_w2 !== exp_res.read_w2) begin
            $error("read_w2: expected %h, got %h", exp_res.read_w2, got.read_w2);
            mismatch_count++;
        end
        if (got.read_w3 !== exp_res.read_w3) begin
            $error("read_w3: expected %h, got %h", exp_res.read_w3, got.read_w3);
            mismatch_count++;
        end
        if (got.depth_now !== exp_res.depth_now) begin
            $error("depth_now: expected %0d, got %0d", exp_res.depth_now, got.depth_now);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res oldest;
        if (!i_rst_n) begin
            due_results.delete();
            stk_depth    = 0;
            queued_count = 0;
        end else begin
            // a result never belongs to a request taken at the same edge
            if (i_done) begin
                if (due_results.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    mismatch_count++;
                end else begin
                    oldest = due_results.pop_front();
                    compare_result(oldest, i_res);
                end
            end
            if (i_start && !i_busy) begin
                due_results.push_back(apply_request(i_req));
            end
            queued_count = due_results.size();
        end
    end

endmodule

// ===== dv/tb_word_stack_with_dup_swap.sv =====
`timescale 1ns / 100ps
// top of the word stack regression: clock, reset, request stimulus and verdict
// depends on wsds_pkg, word_stack_with_dup_swap and wsds_stack_checker
module tb_word_stack_with_dup_swap;
    import wsds_pkg::*;

    // request code with no operation behind it, must leave the stack alone
    localparam logic [TYPE_W-1:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_REQS  = 725;
    // random requests from this index on go back to back
    localparam int IDLE_CUTOFF  = 650;
    // worst case is about 750 requests, each a swap plus the longest idle burst
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_req  i_req = '0;
    logic  busy;
    logic  o_done;
    t_res  o_res;

    int    fail_count;
    int    pending;
    int    cycle_count = 0;
    bit    idle_on;
    bit    grow_mode;

    always #10 i_clk = ~i_clk;

    word_stack_with_dup_swap DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    wsds_stack_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog, covers a hung handshake or a lost result
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("word_stack_with_dup_swap regression: fail");
            $finish;
        end
    end

    // limbs lean toward all-zero and all-one now and then so both extremes show up
    function automatic t_word rand_word();
        t_word w;
        logic [LIMB_W-1:0] limb [4];
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0:       limb[k] = '0;
                1:       limb[k] = '1;
                default: limb[k] = {$urandom, $urandom};
            endcase
        end
        w.w0 = limb[0];
        w.w1 = limb[1];
        w.w2 = limb[2];
        w.w3 = limb[3];
        return w;
    endfunction

    // drive one request and hold it until the block takes it; start is left high
    // so a following request can go out at the very next edge
    task automatic send(input logic [TYPE_W-1:0] op, input int unsigned pos, input t_word w);
        t_req r;
        r.req_type = op;
        r.position = pos[POS_W-1:0];
        r.data_w0  = w.w0;
        r.data_w1  = w.w1;
        r.data_w2  = w.w2;
        r.data_w3  = w.w3;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    // random idle burst on the request side, issued in the step the last request was taken
    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // get/set index: mostly near the top, sometimes anywhere in the 10-bit range
    function automatic int unsigned pick_index();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, 23);
    endfunction

    // dup/swap count: mostly legal, sometimes zero or beyond the reach limit
    function automatic int unsigned pick_count();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return MAX_REACH + 1;
            2:       return $urandom_range(0, 1023);
            default: return $urandom_range(1, MAX_REACH);
        endcase
    endfunction

    // one random request; the op mix leans toward growth or shrinkage by phase
    task automatic send_random(input bit grow);
        int unsigned pick;
        int unsigned push_hi;
        int unsigned pop_hi;
        pick    = $urandom_range(0, 99);
        push_hi = grow ? 40 : 20;
        pop_hi  = grow ? 50 : 45;
        if (pick < push_hi) begin
            send(OP_PUSH, $urandom_range(0, 1023), rand_word());
        end else if (pick < pop_hi) begin
            send(OP_POP, $urandom_range(0, 1023), rand_word());
        end else if (pick < 62) begin
            send(OP_GET, pick_index(), rand_word());
        end else if (pick < 72) begin
            send(OP_SET, pick_index(), rand_word());
        end else if (pick < 83) begin
            send(OP_DUP, pick_count(), rand_word());
        end else if (pick < 96) begin
            send(OP_SWAP, pick_count(), rand_word());
        end else if (pick < 98) begin
            send(OP_CLEAR, $urandom_range(0, 1023), rand_word());
        end else begin
            send(OP_UNUSED, $urandom_range(0, 1023), rand_word());
        end
    endtask

    initial begin
        t_word ones;
        t_word zeros;
        t_word stripes;
        ones    = '1;
        zeros   = '0;
        stripes = {4{64'hA5A5_5A5A_0F0F_F0F0}};

        // synchronous reset held low from the start, released on an edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: error cases on the empty stack ----
        send(OP_POP, 0, ones);             // pop when empty, underflow
        send(OP_GET, 0, ones);             // peek when empty, out of range
        send(OP_SET, 0, ones);             // set when empty, out of range
        send(OP_DUP, 1, ones);             // dup with too few entries
        maybe_idle(1'b1);
        send(OP_SWAP, 1, ones);            // swap with too few entries
        send(OP_DUP, 0, ones);             // count of zero, bad count wins over underflow
        send(OP_SWAP, MAX_REACH + 1, ones); // count beyond reach
        send(OP_UNUSED, 1023, ones);       // unused code, nothing happens

        // ---- directed: a few entries with extreme words ----
        send(OP_PUSH, 0, ones);
        send(OP_PUSH, 1023, zeros);
        send(OP_PUSH, 0, stripes);
        send(OP_PUSH, 0, ~stripes);
        send(OP_GET, 0, zeros);            // peek
        send(OP_GET, 3, zeros);            // deepest entry
        send(OP_GET, 4, zeros);            // one past the bottom
        send(OP_SET, 2, ~ones);
        send(OP_DUP, 4, zeros);            // copy the bottom entry onto the top
        send(OP_SWAP, 4, zeros);           // swap top with bottom, depth exactly n+1
        send(OP_SWAP, 5, zeros);           // one entry short
        send(OP_DUP, MAX_REACH, zeros);    // legal count, too few entries
        send(OP_SET, 1023, ones);          // far out of range
        send(OP_POP, 0, zeros);
        send(OP_CLEAR, 0, zeros);
        send(OP_POP, 0, zeros);            // cleared stack is empty again

        // ---- random: phases of growth and shrinkage, idle stretches switched on and off ----
        idle_on   = 1'b1;
        grow_mode = 1'b1;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 50 == 0) idle_on = ($urandom_range(0, 2) != 0);
            if (n % 40 == 0) grow_mode = ($urandom_range(0, 2) != 0);
            send_random(grow_mode);
            maybe_idle(idle_on && n < IDLE_CUTOFF);
        end
        start <= 1'b0;

        // every result must be in before the verdict, then a short tail for strays
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("word_stack_with_dup_swap regression: pass");
        end else begin
            $display("word_stack_with_dup_swap regression: fail");
        end
        $finish;
    end

endmodule
